/* rtl/dsts_pkg.sv */
// Shared constants, field layout and types of the DDPM step temporal smoother.
package dsts_pkg;

  localparam int unsigned MAX_FRAMES      = 64;
  localparam int unsigned MAX_FRAME_ELEMS = 4096;
  localparam int unsigned SAMPLE_BITS     = 24;
  localparam int unsigned COEF_BITS       = 18;

  localparam int unsigned FRAME_W = $clog2(MAX_FRAMES);
  localparam int unsigned ELEM_W  = $clog2(MAX_FRAME_ELEMS);
  localparam int unsigned FCNT_W  = FRAME_W + 1;
  localparam int unsigned ECNT_W  = ELEM_W + 1;

  // Configuration registers
  localparam int unsigned CFG_FC_W   = 7;
  localparam int unsigned CFG_FE_W   = 13;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned W_ONE      = 65536;

  localparam int unsigned FC_RESET     = (16 > MAX_FRAMES) ? MAX_FRAMES : 16;
  localparam int unsigned FE_RESET     = (4096 > MAX_FRAME_ELEMS) ? MAX_FRAME_ELEMS : 4096;
  localparam int unsigned WEIGHT_RESET = 13107;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT = 2'd0,
    CFG_FRAME_ELEMS = 2'd1,
    CFG_WEIGHT      = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_e;

  // Input tdata layout, lowest field first
  localparam int unsigned IN_FRAME_LSB  = 0;
  localparam int unsigned IN_SCALE_LSB  = IN_FRAME_LSB + FRAME_W;
  localparam int unsigned IN_NCOEF_LSB  = IN_SCALE_LSB + COEF_BITS;
  localparam int unsigned IN_SAMPLE_LSB = IN_NCOEF_LSB + COEF_BITS;
  localparam int unsigned IN_NOISE_LSB  = IN_SAMPLE_LSB + SAMPLE_BITS;
  localparam int unsigned IN_FIELDS_W   = IN_NOISE_LSB + SAMPLE_BITS;
  localparam int unsigned IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

  // Output tdata layout, lowest field first
  localparam int unsigned OUT_FIELDS_W = SAMPLE_BITS + FRAME_W + ELEM_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Memory entries
  localparam int unsigned COEF_ENTRY_W  = 2 * COEF_BITS;
  localparam int unsigned FRAME_ENTRY_W = 2 * SAMPLE_BITS;

  typedef struct packed {
    logic                          run_end;
    logic [ELEM_W-1:0]             element;
    logic [FRAME_W-1:0]            frame;
    logic signed [SAMPLE_BITS-1:0] value;
  } result_t;

  // Stage enables from the sequencer to the datapath
  typedef struct packed {
    logic load_in;
    logic prod1;
    logic diff;
    logic prod2;
    logic cur;
    logic smooth_mul;
    logic smooth_sum;
  } dp_ctrl_t;

endpackage

/* rtl/ddpm_step_temporal_smoother_top.sv */
// Top level of the DDPM reverse step with three-tap temporal smoothing.
//
// Usage:
//   s_axis carries load and sample transactions; tuser is the opcode. A load writes
//   one frame's scale and noise coefficients into the 64-entry coefficient RAM. A
//   sample is denoised with its frame's coefficients and blended with the two
//   previous denoised frames kept in a 4096-entry history RAM.
//   m_axis carries results; tlast marks the last result of a sample transaction.
//   A sample yields zero, one or two results (a final frame from frame 2 on emits the
//   smoothed previous frame and then itself, interleaved element by element).
//   cfg writes frame count, frame size and neighbor weight; it is always ready and
//   a geometry write restarts the clip at frame 0, element 0.
// Timing:
//   A sample passes the accept state, six arithmetic stages (PROD1, DIFF, PROD2,
//   CUR, SMUL, SSUM) that include one read-modify-write of the history RAM, and
//   the queue state EMIT, which pushes its results into the output buffer. No new
//   sample or load is taken until EMIT ends; one load per cycle while idle.
// Reset and stall:
//   Reset restores the register defaults and the stream position; RAM contents
//   stay undefined until written. When m_axis stalls, up to two results wait in the
//   output buffer; the block holds EMIT until the new results fit, then continues.
module ddpm_step_temporal_smoother_top (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: coef_frame, scale_coef, noise_coef, sample, noise_sample (low to high)
  input  logic [dsts_pkg::IN_DATA_W-1:0]         s_axis_tdata,
  // tuser: opcode
  input  logic                                   s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata: out_value, out_frame, out_element (low to high)
  output logic [dsts_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // tlast: run_end
  output logic                                   m_axis_tlast,
  // Configuration writes
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dsts_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dsts_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import dsts_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PROD1 = 8'b0000_0010,
    ST_DIFF  = 8'b0000_0100,
    ST_PROD2 = 8'b0000_1000,
    ST_CUR   = 8'b0001_0000,
    ST_SMUL  = 8'b0010_0000,
    ST_SSUM  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration, stored already clamped to the legal range
  logic [FCNT_W-1:0]   frames_eff_q, frames_eff_d;
  logic [ECNT_W-1:0]   elems_eff_q, elems_eff_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;

  // Stream position and the context of the sample in flight
  logic [FRAME_W-1:0]  frame_pos_q, frame_pos_d;
  logic [ELEM_W-1:0]   element_pos_q, element_pos_d;
  logic [FRAME_W-1:0]  f_q;
  logic [ELEM_W-1:0]   e_q;
  logic                last_q;

  logic cfg_acc, in_acc, smp_acc, load_acc, geom_wr;
  logic pos_is_last, elem_wrap;
  logic [CFG_FC_W-1:0] fc_raw;
  logic [CFG_FE_W-1:0] fe_raw;
  logic [WEIGHT_W-1:0] w_raw;

  logic [COEF_BITS-1:0]     in_scale, in_ncoef;
  logic [COEF_ENTRY_W-1:0]  coef_rdata;
  logic [FRAME_ENTRY_W-1:0] frame_rdata, frame_wdata;
  logic signed [SAMPLE_BITS-1:0] cur, smooth;

  dp_ctrl_t          dp_ctrl;
  result_t [1:0]     push_res;
  logic [1:0]        push_n, push_cnt, buf_free;
  logic              emit_go, f_ge2;
  logic [FRAME_W-1:0] f_prev;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign smp_acc       = in_acc && (s_axis_tuser == OP_SAMPLE);
  assign load_acc      = in_acc && (s_axis_tuser == OP_LOAD);

  assign in_scale = s_axis_tdata[IN_SCALE_LSB +: COEF_BITS];
  assign in_ncoef = s_axis_tdata[IN_NCOEF_LSB +: COEF_BITS];

  // ---------------------------------------------------------------------------
  // Configuration decode: clamp zero counts to one, oversize values to the maximum
  // ---------------------------------------------------------------------------
  assign fc_raw = cfg_data_i[CFG_FC_W-1:0];
  assign fe_raw = cfg_data_i[CFG_FE_W-1:0];
  assign w_raw  = cfg_data_i[WEIGHT_W-1:0];

  always_comb begin
    frames_eff_d = frames_eff_q;
    elems_eff_d  = elems_eff_q;
    weight_d     = weight_q;
    geom_wr      = 1'b0;
    if (cfg_acc) begin
      unique case (cfg_index_i)
        CFG_FRAME_COUNT: begin
          geom_wr = 1'b1;
          if (fc_raw == '0) begin
            frames_eff_d = FCNT_W'(1);
          end else if (int'(fc_raw) > int'(MAX_FRAMES)) begin
            frames_eff_d = FCNT_W'(MAX_FRAMES);
          end else begin
            frames_eff_d = FCNT_W'(fc_raw);
          end
        end
        CFG_FRAME_ELEMS: begin
          geom_wr = 1'b1;
          if (fe_raw == '0) begin
            elems_eff_d = ECNT_W'(1);
          end else if (int'(fe_raw) > int'(MAX_FRAME_ELEMS)) begin
            elems_eff_d = ECNT_W'(MAX_FRAME_ELEMS);
          end else begin
            elems_eff_d = ECNT_W'(fe_raw);
          end
        end
        CFG_WEIGHT: begin
          if (int'(w_raw) > int'(W_ONE)) begin
            weight_d = WEIGHT_W'(W_ONE);
          end else begin
            weight_d = w_raw;
          end
        end
        default: begin
          // unknown index: drop the write
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stream position: advance on every sample, restart on a geometry write, wrap at frame and clip end
  // ---------------------------------------------------------------------------
  assign pos_is_last = (FCNT_W'(frame_pos_q) == (frames_eff_q - FCNT_W'(1)));
  assign elem_wrap   = ((ECNT_W'(element_pos_q) + ECNT_W'(1)) == elems_eff_q);

  always_comb begin
    frame_pos_d   = frame_pos_q;
    element_pos_d = element_pos_q;
    if (geom_wr) begin
      frame_pos_d   = '0;
      element_pos_d = '0;
    end else if (smp_acc) begin
      if (elem_wrap) begin
        element_pos_d = '0;
        frame_pos_d   = pos_is_last ? '0 : frame_pos_q + FRAME_W'(1);
      end else begin
        element_pos_d = element_pos_q + ELEM_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: one sample at a time through the shared arithmetic chain
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (smp_acc) state_d = ST_PROD1;
      ST_PROD1: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_PROD2;
      ST_PROD2: state_d = ST_CUR;
      ST_CUR:   state_d = ST_SMUL;
      ST_SMUL:  state_d = ST_SSUM;
      ST_SSUM:  state_d = ST_EMIT;
      ST_EMIT:  if (emit_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign dp_ctrl.load_in    = smp_acc;
  assign dp_ctrl.prod1      = (state_q == ST_PROD1);
  assign dp_ctrl.diff       = (state_q == ST_DIFF);
  assign dp_ctrl.prod2      = (state_q == ST_PROD2);
  assign dp_ctrl.cur        = (state_q == ST_CUR);
  assign dp_ctrl.smooth_mul = (state_q == ST_SMUL);
  assign dp_ctrl.smooth_sum = (state_q == ST_SSUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      frames_eff_q  <= FCNT_W'(FC_RESET);
      elems_eff_q   <= ECNT_W'(FE_RESET);
      weight_q      <= WEIGHT_W'(WEIGHT_RESET);
      frame_pos_q   <= '0;
      element_pos_q <= '0;
    end else begin
      state_q       <= state_d;
      frames_eff_q  <= frames_eff_d;
      elems_eff_q   <= elems_eff_d;
      weight_q      <= weight_d;
      frame_pos_q   <= frame_pos_d;
      element_pos_q <= element_pos_d;
    end
  end

  // Capture where the accepted sample sits in the clip
  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      f_q    <= frame_pos_q;
      e_q    <= element_pos_q;
      last_q <= pos_is_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories. The history entry is read at accept and written back in ST_SMUL;
  // the next sample is accepted only after that, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  dsts_ram #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (COEF_ENTRY_W)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (load_acc),
    .waddr_i (s_axis_tdata[IN_FRAME_LSB +: FRAME_W]),
    .wdata_i ({in_scale, in_ncoef}),
    .re_i    (smp_acc),
    .raddr_i (frame_pos_q),
    .rdata_o (coef_rdata)
  );

  dsts_ram #(
    .DEPTH (MAX_FRAME_ELEMS),
    .WIDTH (FRAME_ENTRY_W)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_SMUL),
    .waddr_i (e_q),
    .wdata_i (frame_wdata),
    .re_i    (smp_acc),
    .raddr_i (element_pos_q),
    .rdata_o (frame_rdata)
  );

  dsts_datapath u_datapath (
    .clk_i         (clk_i),
    .ctrl_i        (dp_ctrl),
    .sample_i      ($signed(s_axis_tdata[IN_SAMPLE_LSB +: SAMPLE_BITS])),
    .noise_i       ($signed(s_axis_tdata[IN_NOISE_LSB +: SAMPLE_BITS])),
    .coef_rdata_i  (coef_rdata),
    .frame_rdata_i (frame_rdata),
    .weight_i      (weight_q),
    .cur_o         (cur),
    .smooth_o      (smooth),
    .frame_wdata_o (frame_wdata)
  );

  // ---------------------------------------------------------------------------
  // Result selection: frame 0 passes through; from frame 2 on the previous frame
  // is emitted smoothed; the clip's last frame then passes through as well.
  // ---------------------------------------------------------------------------
  assign f_ge2  = (f_q[FRAME_W-1:1] != '0);
  assign f_prev = f_q - FRAME_W'(1);

  always_comb begin
    push_n   = 2'd0;
    push_res = '0;
    if (f_q == '0) begin
      push_n   = 2'd1;
      push_res[0] = '{run_end: 1'b1, element: e_q, frame: f_q, value: cur};
    end else if (f_ge2 && last_q) begin
      push_n   = 2'd2;
      push_res[0] = '{run_end: 1'b0, element: e_q, frame: f_prev, value: smooth};
      push_res[1] = '{run_end: 1'b1, element: e_q, frame: f_q, value: cur};
    end else if (f_ge2) begin
      push_n   = 2'd1;
      push_res[0] = '{run_end: 1'b1, element: e_q, frame: f_prev, value: smooth};
    end else if (last_q) begin
      push_n   = 2'd1;
      push_res[0] = '{run_end: 1'b1, element: e_q, frame: f_q, value: cur};
    end
  end

  // Hold in ST_EMIT until the buffer has room for every result of this sample
  assign emit_go  = (state_q == ST_EMIT) && (buf_free >= push_n);
  assign push_cnt = emit_go ? push_n : 2'd0;

  dsts_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_cnt_i    (push_cnt),
    .push_i        (push_res),
    .free_o        (buf_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FCNT_W'(frame_pos_q) < frames_eff_q) && (ECNT_W'(element_pos_q) < elems_eff_q))
    else $error("stream position outside the configured clip geometry");

  a_load_keeps_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_acc && !cfg_acc) |=> ($stable(frame_pos_q) && $stable(element_pos_q)))
    else $error("load transaction moved the stream position");

  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    smp_acc |=> (state_q == ST_PROD1))
    else $error("accepted sample did not enter the arithmetic chain");

  a_frame0_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[SAMPLE_BITS +: FRAME_W] == '0)) |-> m_axis_tlast)
    else $error("frame 0 result not marked as end of run");

endmodule

/* rtl/dsts_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
module dsts_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dsts_datapath.sv */
// Fixed-point datapath: denoise step, then three-tap temporal blend.
module dsts_datapath (
  input  logic                                       clk_i,
  input  dsts_pkg::dp_ctrl_t                         ctrl_i,
  input  logic signed [dsts_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic signed [dsts_pkg::SAMPLE_BITS-1:0]    noise_i,
  input  logic [dsts_pkg::COEF_ENTRY_W-1:0]          coef_rdata_i,
  input  logic [dsts_pkg::FRAME_ENTRY_W-1:0]         frame_rdata_i,
  input  logic [dsts_pkg::WEIGHT_W-1:0]              weight_i,
  output logic signed [dsts_pkg::SAMPLE_BITS-1:0]    cur_o,
  output logic signed [dsts_pkg::SAMPLE_BITS-1:0]    smooth_o,
  output logic [dsts_pkg::FRAME_ENTRY_W-1:0]         frame_wdata_o
);
  import dsts_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned P1_W   = COEF_BITS + 1 + SB;
  localparam int unsigned P1R_W  = P1_W - 16;
  localparam int unsigned DIFF_W = P1R_W + 1;
  localparam int unsigned P2_W   = COEF_BITS + 1 + DIFF_W;
  localparam int unsigned P2R_W  = P2_W - 16;
  localparam int unsigned SUM_W  = SB + 1;
  localparam int unsigned M1_W   = WEIGHT_W + 1 + SB;
  localparam int unsigned M2_W   = WEIGHT_W + 1 + SUM_W;
  localparam int unsigned NUM_W  = M2_W + 1;
  localparam int unsigned NUMR_W = NUM_W - 17;

  localparam logic signed [P1_W-1:0]  P1_HALF  = P1_W'(32'sd32768);
  localparam logic signed [P2_W-1:0]  P2_HALF  = P2_W'(32'sd32768);
  localparam logic signed [NUM_W-1:0] NUM_HALF = NUM_W'(32'sd65536);
  localparam logic [WEIGHT_W-1:0]     W_ONE_V  = WEIGHT_W'(W_ONE);

  function automatic logic signed [SB-1:0] sat_p2(input logic signed [P2R_W-1:0] v);
    logic signed [P2R_W-1:0] hi;
    logic signed [P2R_W-1:0] lo;
    hi = {{(P2R_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[SB-1:0];
    if (v < lo) return lo[SB-1:0];
    return v[SB-1:0];
  endfunction

  function automatic logic signed [SB-1:0] sat_num(input logic signed [NUMR_W-1:0] v);
    logic signed [NUMR_W-1:0] hi;
    logic signed [NUMR_W-1:0] lo;
    hi = {{(NUMR_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
    lo = ~hi;
    if (v > hi) return hi[SB-1:0];
    if (v < lo) return lo[SB-1:0];
    return v[SB-1:0];
  endfunction

  logic signed [SB-1:0]       x_q, nz_q;
  logic signed [P1_W-1:0]     prod1_q, prod1_d, p1_sum;
  logic [COEF_BITS-1:0]       scale_q;
  logic signed [SB-1:0]       older_q, newer_q;
  logic signed [P1R_W-1:0]    p_rnd;
  logic signed [DIFF_W-1:0]   diff_q, diff_d;
  logic signed [P2_W-1:0]     prod2_q, prod2_d, p2_sum;
  logic signed [P2R_W-1:0]    p2_rnd;
  logic signed [SB-1:0]       cur_q, cur_d;
  logic [WEIGHT_W-1:0]        a_w;
  logic signed [SUM_W-1:0]    bsum;
  logic signed [M1_W-1:0]     m1_q, m1_d;
  logic signed [M2_W-1:0]     m2_q, m2_d;
  logic signed [NUM_W-1:0]    num;
  logic signed [NUMR_W-1:0]   num_rnd;
  logic signed [SB-1:0]       smooth_q, smooth_d;
  logic [COEF_BITS-1:0]       ncoef;

  assign ncoef   = coef_rdata_i[COEF_BITS-1:0];
  assign prod1_d = $signed({1'b0, ncoef}) * nz_q;

  // Round the Q2.16 coefficient product to signed sample units: add half an LSB, floor
  assign p1_sum = prod1_q + P1_HALF;
  assign p_rnd  = p1_sum[P1_W-1:16];
  assign diff_d = DIFF_W'(x_q) - DIFF_W'(p_rnd);

  assign prod2_d = $signed({1'b0, scale_q}) * diff_q;
  assign p2_sum  = prod2_q + P2_HALF;
  assign p2_rnd  = p2_sum[P2_W-1:16];
  assign cur_d   = sat_p2(p2_rnd);

  assign a_w  = W_ONE_V - weight_i;
  assign bsum = SUM_W'(older_q) + SUM_W'(cur_q);
  assign m1_d = $signed({1'b0, a_w}) * newer_q;
  assign m2_d = $signed({1'b0, weight_i}) * bsum;

  assign num      = (NUM_W'(m1_q) <<< 1) + NUM_W'(m2_q) + NUM_HALF;
  assign num_rnd  = num[NUM_W-1:17];
  assign smooth_d = sat_num(num_rnd);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      x_q  <= sample_i;
      nz_q <= noise_i;
    end
    if (ctrl_i.prod1) begin
      prod1_q <= prod1_d;
      scale_q <= coef_rdata_i[COEF_ENTRY_W-1 -: COEF_BITS];
      older_q <= frame_rdata_i[FRAME_ENTRY_W-1 -: SB];
      newer_q <= frame_rdata_i[SB-1:0];
    end
    if (ctrl_i.diff) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.prod2) begin
      prod2_q <= prod2_d;
    end
    if (ctrl_i.cur) begin
      cur_q <= cur_d;
    end
    if (ctrl_i.smooth_mul) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
    end
    if (ctrl_i.smooth_sum) begin
      smooth_q <= smooth_d;
    end
  end

  assign cur_o         = cur_q;
  assign smooth_o      = smooth_q;
  // Shift the history: the old newer frame becomes the older one
  assign frame_wdata_o = {newer_q, cur_q};

endmodule

/* rtl/dsts_out_buf.sv */
// Two-entry result buffer driving the master stream; takes up to two results at once.
module dsts_out_buf (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  dsts_pkg::result_t [1:0]           push_i,
  output logic [1:0]                        free_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dsts_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);
  import dsts_pkg::*;

  result_t [1:0] slot_q, slot_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign pop = m_axis_tvalid && m_axis_tready;

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (pop) begin
      slot_d[0] = slot_q[1];
      cnt_d     = cnt_q - 2'd1;
    end
    if (push_cnt_i != 2'd0) begin
      slot_d[cnt_d[0]] = push_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      slot_d[1] = push_i[1];
    end
    cnt_d = cnt_d + push_cnt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign free_o        = 2'd2 - cnt_q;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = OUT_DATA_W'({slot_q[0].element, slot_q[0].frame, slot_q[0].value});
  assign m_axis_tlast  = slot_q[0].run_end;

endmodule
